// ===== sv/stpd_pkg.sv =====
// Shared types, codes and item field positions for the soft timer dispatcher.
`default_nettype none
package stpd_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int LEVELS_DEF = 4;

  localparam logic [15:0] NO_ID       = 16'hFFFF;
  localparam logic [1:0]  LEVEL_NORM  = 2'd1;
  localparam int          ACT_W       = 5;
  localparam int          ACT_MAX     = 31;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 1;

  // input tdata positions
  localparam int I_TAG_LO  = 0;
  localparam int I_ID_LO   = 32;
  localparam int I_BYTAG   = 48;
  localparam int I_PER_LO  = 49;
  localparam int I_LVL_LO  = 81;
  localparam int I_ONE     = 83;
  // input tuser positions
  localparam int I_OP_LO   = 0;
  localparam int I_KIND    = 3;

  // output tdata positions
  localparam int O_OK      = 0;
  localparam int O_GID_LO  = 1;
  localparam int O_DISP    = 17;
  localparam int O_TAG_LO  = 18;
  localparam int O_ACT_LO  = 50;
  localparam int O_NOW_LO  = 55;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_SUSPEND  = 3'd3,
    OP_RESUME   = 3'd4,
    OP_DISPATCH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_RUNNING   = 2'd1,
    MODE_SUSPENDED = 2'd2
  } mode_t;

endpackage
`default_nettype wire

// ===== sv/stpd_active.sv =====
// Saturating count of live timer slots, registered.
`default_nettype none
module stpd_active #(
  parameter int SLOTS = stpd_pkg::SLOTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic [SLOTS-1:0]          live,
  output logic [stpd_pkg::ACT_W-1:0]     active_r
);
  import stpd_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  logic [CW-1:0]    sum;
  logic [ACT_W-1:0] active_nxt;

  always_comb begin
    sum = '0;
    for (int i = 0; i < SLOTS; i++) sum = sum + CW'(live[i]);
    if (32'(sum) > ACT_MAX) active_nxt = ACT_W'(ACT_MAX);
    else active_nxt = ACT_W'(sum);
  end

  always_ff @(posedge clk) begin
    active_r <= active_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/soft_timer_priority_dispatcher_unit.sv =====
// Top level: timer slot table, per-level ready queues and the command sequencer.
//
//  channel | ports                          | contents
//  in      | in_tvalid/in_tready/in_tdata/  | one command item (tick, start, stop,
//          | in_tuser                       |   suspend, resume, dispatch)
//  out     | out_tvalid/out_tready/out_tdata| one result item per command
//          | /out_tuser                     |
//
// Tick walks every slot, one per cycle. Start walks to the first stopped slot;
// stop, suspend and resume to the matching slot. If the slot is queued, all
// slots are swept once to close the gap. Dispatch finds the top head, then sweeps.
// Queue order is kept as a per-slot position; one compare/decrement unit serves.
// Reset (rst_n low, synchronous) stops every slot and empties every queue.
// in_tready is high only while idle; a held result lets the next item in but
// holds that item in its last step until out_tready.
`default_nettype none
module soft_timer_priority_dispatcher_unit #(
  parameter int SLOTS           = stpd_pkg::SLOTS_DEF,
  parameter int PRIORITY_LEVELS = stpd_pkg::LEVELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // handle_tag, lookup_id, by_tag, period, level, single_shot, zero pad
  input  wire logic [stpd_pkg::IN_DATA_W-1:0]      in_tdata,
  // op, kind
  input  wire logic [stpd_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // ok, given_id, dispatched, out_tag, active_slots, now_ticks, zero pad
  output logic [stpd_pkg::OUT_DATA_W-1:0]          out_tdata,
  // out_kind
  output logic [stpd_pkg::OUT_USER_W-1:0]          out_tuser
);
  import stpd_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_FREE, S_FIND, S_DISPQ, S_DROP, S_APPLY, S_WRAP, S_LOAD
  } state_t;

  state_t state_r;

  mode_t       mode_r  [SLOTS];
  logic [31:0] tag_r   [SLOTS];
  logic [31:0] per_r   [SLOTS];
  logic [31:0] cnt_r   [SLOTS];
  logic [3:0]  flags_r [SLOTS];
  logic [15:0] ident_r [SLOTS];
  logic        qv_r    [SLOTS];
  logic [SW-1:0] qpos_r [SLOTS];
  logic [CW-1:0] qcnt_r [4];

  logic [15:0] idc_r;
  logic [31:0] now_r;

  op_t         op_r;
  logic [31:0] itag_r, iper_r;
  logic [15:0] iid_r;
  logic        ibytag_r, ione_r, ikind_r;
  logic [1:0]  ilvl_r;

  logic [SW-1:0] idx_r, hit_r, dk_r;
  logic [1:0]    dl_r;
  logic          ok_r, disp_r, okind_r;
  logic [15:0]   gid_r;
  logic [31:0]   otag_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  logic [SLOTS-1:0]  live;
  logic [ACT_W-1:0]  active;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) live[i] = (mode_r[i] != MODE_STOPPED);
  end

  stpd_active #(.SLOTS(SLOTS)) u_active (
    .clk      (clk),
    .live     (live),
    .active_r (active)
  );

  // slot at the walk index
  mode_t       cur_mode;
  logic [1:0]  cur_lvl;
  logic [31:0] cur_dec;
  logic        cur_lvl_ok, cur_match;
  logic [1:0]  top_lvl;
  logic        top_found;

  always_comb begin
    cur_mode   = mode_r[idx_r];
    cur_lvl    = flags_r[idx_r][1:0];
    cur_lvl_ok = (int'(cur_lvl) < PRIORITY_LEVELS);
    cur_dec    = cnt_r[idx_r] - 32'd1;
    cur_match  = (cur_mode != MODE_STOPPED) &&
                 (ibytag_r ? (tag_r[idx_r] == itag_r) : (ident_r[idx_r] == iid_r));
    top_lvl    = '0;
    top_found  = 1'b0;
    for (int l = 0; l < 4; l++) begin
      if (l < PRIORITY_LEVELS && qcnt_r[l] != '0) begin
        top_lvl   = 2'(l);
        top_found = 1'b1;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      idc_r        <= 16'd1;
      now_r        <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        mode_r[i]  <= MODE_STOPPED;
        tag_r[i]   <= '0;
        per_r[i]   <= '0;
        cnt_r[i]   <= '0;
        flags_r[i] <= {2'b00, LEVEL_NORM};
        ident_r[i] <= NO_ID;
        qv_r[i]    <= 1'b0;
      end
      for (int l = 0; l < 4; l++) qcnt_r[l] <= '0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_LOAD) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= op_t'(in_tuser[I_OP_LO +: 3]);
            ikind_r  <= in_tuser[I_KIND];
            itag_r   <= in_tdata[I_TAG_LO +: 32];
            iid_r    <= in_tdata[I_ID_LO +: 16];
            ibytag_r <= in_tdata[I_BYTAG];
            iper_r   <= in_tdata[I_PER_LO +: 32];
            ilvl_r   <= in_tdata[I_LVL_LO +: 2];
            ione_r   <= in_tdata[I_ONE];
            idx_r    <= '0;
            ok_r     <= 1'b0;
            disp_r   <= 1'b0;
            gid_r    <= '0;
            otag_r   <= '0;
            okind_r  <= 1'b0;
            unique case (in_tuser[I_OP_LO +: 3])
              OP_TICK: begin
                now_r   <= now_r + 32'd1;
                state_r <= S_TICK;
              end
              OP_START: state_r <= S_FREE;
              OP_STOP, OP_SUSPEND, OP_RESUME: state_r <= S_FIND;
              OP_DISPATCH: begin
                dl_r    <= top_lvl;
                dk_r    <= '0;
                state_r <= top_found ? S_DISPQ : S_WRAP;
              end
              default: state_r <= S_WRAP;
            endcase
          end
        end
        S_TICK: begin
          if (cur_mode == MODE_RUNNING && cnt_r[idx_r] != '0) begin
            if (cur_dec == '0 && cur_lvl_ok) begin
              if (!qv_r[idx_r]) begin
                qv_r[idx_r]     <= 1'b1;
                qpos_r[idx_r]   <= SW'(qcnt_r[cur_lvl]);
                qcnt_r[cur_lvl] <= qcnt_r[cur_lvl] + CW'(1);
              end
              if (flags_r[idx_r][2]) begin
                mode_r[idx_r] <= MODE_STOPPED;
                cnt_r[idx_r]  <= cur_dec;
              end else begin
                cnt_r[idx_r] <= per_r[idx_r];
              end
            end else begin
              cnt_r[idx_r] <= cur_dec;
            end
          end
          if (idx_r == LAST) state_r <= S_WRAP;
          else idx_r <= idx_r + SW'(1);
        end
        S_FREE: begin
          if (cur_mode == MODE_STOPPED) begin
            hit_r <= idx_r;
            if (qv_r[idx_r]) begin
              qv_r[idx_r]     <= 1'b0;
              qcnt_r[cur_lvl] <= qcnt_r[cur_lvl] - CW'(1);
              dl_r            <= cur_lvl;
              dk_r            <= qpos_r[idx_r];
              idx_r           <= '0;
              state_r         <= S_DROP;
            end else begin
              state_r <= S_APPLY;
            end
          end else if (idx_r == LAST) begin
            gid_r   <= NO_ID;
            state_r <= S_WRAP;
          end else begin
            idx_r <= idx_r + SW'(1);
          end
        end
        S_FIND: begin
          if (cur_match) begin
            hit_r <= idx_r;
            // a found slot ends the search even when its mode refuses the op
            if (op_r == OP_RESUME) begin
              if (cur_mode == MODE_SUSPENDED) begin
                ok_r    <= 1'b1;
                state_r <= S_APPLY;
              end else begin
                state_r <= S_WRAP;
              end
            end else if (op_r == OP_SUSPEND && cur_mode != MODE_RUNNING) begin
              state_r <= S_WRAP;
            end else begin
              ok_r <= 1'b1;
              if (qv_r[idx_r]) begin
                qv_r[idx_r]     <= 1'b0;
                qcnt_r[cur_lvl] <= qcnt_r[cur_lvl] - CW'(1);
                dl_r            <= cur_lvl;
                dk_r            <= qpos_r[idx_r];
                idx_r           <= '0;
                state_r         <= S_DROP;
              end else begin
                state_r <= S_APPLY;
              end
            end
          end else if (idx_r == LAST) begin
            state_r <= S_WRAP;
          end else begin
            idx_r <= idx_r + SW'(1);
          end
        end
        S_DISPQ: begin
          if (qv_r[idx_r] && cur_lvl == dl_r && qpos_r[idx_r] == '0) begin
            qv_r[idx_r]  <= 1'b0;
            qcnt_r[dl_r] <= qcnt_r[dl_r] - CW'(1);
            ok_r         <= 1'b1;
            disp_r       <= 1'b1;
            otag_r       <= tag_r[idx_r];
            okind_r      <= flags_r[idx_r][3];
            idx_r        <= '0;
            state_r      <= S_DROP;
          end else if (idx_r == LAST) begin
            state_r <= S_WRAP;
          end else begin
            idx_r <= idx_r + SW'(1);
          end
        end
        S_DROP: begin
          // close the gap behind the removed entry
          if (qv_r[idx_r] && cur_lvl == dl_r && qpos_r[idx_r] > dk_r)
            qpos_r[idx_r] <= qpos_r[idx_r] - SW'(1);
          if (idx_r == LAST) state_r <= S_APPLY;
          else idx_r <= idx_r + SW'(1);
        end
        S_APPLY: begin
          unique case (op_r)
            OP_START: begin
              tag_r[hit_r]   <= itag_r;
              per_r[hit_r]   <= iper_r;
              cnt_r[hit_r]   <= iper_r;
              mode_r[hit_r]  <= MODE_RUNNING;
              flags_r[hit_r] <= {ikind_r, ione_r, ilvl_r};
              ident_r[hit_r] <= idc_r;
              gid_r          <= idc_r;
              ok_r           <= 1'b1;
              idc_r          <= (idc_r == 16'hFFFF) ? 16'd1 : idc_r + 16'd1;
            end
            OP_STOP: begin
              mode_r[hit_r]     <= MODE_STOPPED;
              tag_r[hit_r]      <= '0;
              per_r[hit_r]      <= '0;
              cnt_r[hit_r]      <= '0;
              flags_r[hit_r][2] <= 1'b0;
              ident_r[hit_r]    <= NO_ID;
            end
            OP_SUSPEND: mode_r[hit_r] <= MODE_SUSPENDED;
            OP_RESUME: begin
              mode_r[hit_r] <= MODE_RUNNING;
              cnt_r[hit_r]  <= per_r[hit_r];
            end
            default: ;
          endcase
          state_r <= S_WRAP;
        end
        S_WRAP: state_r <= S_LOAD;  // live count settles
        S_LOAD: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, now_r, active, otag_r, disp_r, gid_r, ok_r};
            out_tuser_r  <= okind_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/stpd_checker.sv =====
// Port-level checks for the soft timer dispatcher, bound to the top level.
`default_nettype none
module stpd_checker #(
  parameter int SLOTS = stpd_pkg::SLOTS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [stpd_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import stpd_pkg::*;

  localparam int MAX_ACT = (SLOTS > ACT_MAX) ? ACT_MAX : SLOTS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_DISP] |-> out_tdata[O_OK])
    else $error("dispatch without ok");

  a_act_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[O_ACT_LO +: ACT_W]) <= MAX_ACT)
    else $error("active count too large");
endmodule

bind soft_timer_priority_dispatcher_unit stpd_checker #(.SLOTS(SLOTS)) u_stpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== verif/tb_soft_timer_priority_dispatcher_unit.sv =====
// Testbench for the soft timer dispatcher: directed and random commands vs a built-in predictor.
`default_nettype none
module tb_soft_timer_priority_dispatcher_unit;
  import stpd_pkg::*;

  localparam int NS = SLOTS_DEF;
  localparam int NL = LEVELS_DEF;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] tag;
    logic [15:0] id;
    logic        by_tag;
    logic [31:0] period;
    logic [1:0]  level;
    logic        one;
    logic        kind;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] gid;
    logic        disp;
    logic [31:0] tag;
    logic        kind;
    logic [4:0]  act;
    logic [31:0] now;
  } res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  soft_timer_priority_dispatcher_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state
  mode_t       t_mode [NS];
  logic [31:0] t_tag [NS], t_per [NS], t_cnt [NS];
  logic [1:0]  t_lvl [NS];
  logic        t_one [NS], t_kind [NS];
  logic [15:0] t_id [NS];
  int          rq [NL][$];
  logic [15:0] next_id;
  logic [31:0] ticks;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   mismatches, results_seen;
  bit   hold_sender;

  // issued ids, for realistic lookups
  logic [15:0] known_ids[$];
  logic [31:0] known_tags[$];

  function automatic void drop_from_queue(int s, int l);
    for (int k = 0; k < rq[l].size(); k++)
      if (rq[l][k] == s) begin
        rq[l].delete(k);
        return;
      end
  endfunction

  function automatic bit push_ready(int s);
    int l;
    l = int'(t_lvl[s]);
    for (int k = 0; k < rq[l].size(); k++) if (rq[l][k] == s) return 1;
    if (rq[l].size() >= NS) return 0;
    rq[l].push_back(s);
    return 1;
  endfunction

  function automatic res_t timer_table_step(cmd_t c);
    res_t r;
    int s, n;
    r = '0;
    s = -1;
    case (c.op)
      OP_TICK: begin
        ticks++;
        for (int i = 0; i < NS; i++) begin
          if (t_mode[i] != MODE_RUNNING || t_cnt[i] == 0) continue;
          t_cnt[i]--;
          if (t_cnt[i] == 0 && push_ready(i)) begin
            if (t_one[i]) t_mode[i] = MODE_STOPPED;
            else t_cnt[i] = t_per[i];
          end
        end
      end
      OP_START: begin
        for (int i = NS - 1; i >= 0; i--) if (t_mode[i] == MODE_STOPPED) s = i;
        if (s >= 0) begin
          for (int l = 0; l < NL; l++) drop_from_queue(s, l);
          t_tag[s] = c.tag; t_per[s] = c.period; t_cnt[s] = c.period;
          t_mode[s] = MODE_RUNNING; t_lvl[s] = c.level; t_one[s] = c.one;
          t_kind[s] = c.kind; t_id[s] = next_id;
          next_id++;
          if (next_id == 0) next_id = 1;
          r.ok = 1; r.gid = t_id[s];
        end else r.gid = NO_ID;
      end
      OP_STOP, OP_SUSPEND, OP_RESUME: begin
        for (int i = NS - 1; i >= 0; i--)
          if (t_mode[i] != MODE_STOPPED &&
              (c.by_tag ? t_tag[i] == c.tag : t_id[i] == c.id)) s = i;
        if (s >= 0) begin
          if (c.op == OP_STOP) begin
            t_mode[s] = MODE_STOPPED; t_tag[s] = 0; t_per[s] = 0; t_cnt[s] = 0;
            t_one[s] = 0; t_id[s] = NO_ID;
            drop_from_queue(s, int'(t_lvl[s]));
            r.ok = 1;
          end else if (c.op == OP_SUSPEND && t_mode[s] == MODE_RUNNING) begin
            t_mode[s] = MODE_SUSPENDED;
            drop_from_queue(s, int'(t_lvl[s]));
            r.ok = 1;
          end else if (c.op == OP_RESUME && t_mode[s] == MODE_SUSPENDED) begin
            t_mode[s] = MODE_RUNNING; t_cnt[s] = t_per[s];
            r.ok = 1;
          end
        end
      end
      OP_DISPATCH: begin
        for (int l = NL - 1; l >= 0; l--)
          if (rq[l].size() != 0) begin
            s = rq[l].pop_front();
            r.ok = 1; r.disp = 1; r.tag = t_tag[s]; r.kind = t_kind[s];
            break;
          end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < NS; i++) if (t_mode[i] != MODE_STOPPED) n++;
    r.act = 5'(n);
    r.now = ticks;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int p;
    c.op = 3'($urandom_range(0, 99) < 40 ? OP_TICK : $urandom_range(1, 7));
    if ($urandom_range(0, 30) == 0) c.op = 3'($urandom_range(6, 7));
    c.tag = (known_tags.size() != 0 && $urandom_range(0, 1)) ?
            known_tags[$urandom_range(0, known_tags.size() - 1)] : $urandom();
    c.id = (known_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
           known_ids[$urandom_range(0, known_ids.size() - 1)] : 16'($urandom());
    c.by_tag = 1'($urandom_range(0, 1));
    p = $urandom_range(0, 19);
    c.period = p < 16 ? 32'(p) : (p < 19 ? 32'($urandom_range(16, 60)) : $urandom());
    c.level = 2'($urandom_range(0, 3));
    c.one = 1'($urandom_range(0, 1));
    c.kind = 1'($urandom_range(0, 1));
    if (c.op == OP_START) begin
      known_tags.push_back(c.tag);
      if (known_tags.size() > 24) void'(known_tags.pop_front());
    end
    return c;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [31:0] tag, logic [15:0] id,
                              logic bt, logic [31:0] per, logic [1:0] lv,
                              logic one, logic kd);
    cmd_t c;
    c.op = op; c.tag = tag; c.id = id; c.by_tag = bt; c.period = per;
    c.level = lv; c.one = one; c.kind = kd;
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      gap = 0;
    end else if (in_tvalid && !in_tready) begin
      // hold
    end else begin
      if (in_tvalid) begin
        void'(pending_cmds.pop_front());
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        gap--;
        in_tvalid <= 0;
      end else if (pending_cmds.size() != 0 && !hold_sender) begin
        in_tvalid <= 1;
        in_tdata  <= {4'b0, pending_cmds[0].one, pending_cmds[0].level,
                      pending_cmds[0].period, pending_cmds[0].by_tag,
                      pending_cmds[0].id, pending_cmds[0].tag};
        in_tuser  <= {pending_cmds[0].kind, pending_cmds[0].op};
      end else in_tvalid <= 0;
    end
  end

  // output stall
  int stall;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      stall = 0;
    end else if (out_tvalid && out_tready) begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
      out_tready <= stall == 0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= stall == 0;
    end else out_tready <= 1;
  end

  // monitor: predict on accept, compare on result
  always @(posedge clk) begin
    cmd_t c;
    res_t e, a;
    if (rst_n && in_tvalid && in_tready) begin
      c = pending_cmds[0];
      e = timer_table_step(c);
      if (c.op == OP_START && e.ok) begin
        known_ids.push_back(e.gid);
        if (known_ids.size() > 24) void'(known_ids.pop_front());
      end
      expected_results.push_back(e);
    end
    if (rst_n && out_tvalid && out_tready) begin
      a.ok = out_tdata[O_OK];
      a.gid = out_tdata[O_GID_LO +: 16];
      a.disp = out_tdata[O_DISP];
      a.tag = out_tdata[O_TAG_LO +: 32];
      a.kind = out_tuser[0];
      a.act = out_tdata[O_ACT_LO +: ACT_W];
      a.now = out_tdata[O_NOW_LO +: 32];
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
      end else begin
        e = expected_results.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p got %p", results_seen, e, a);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 0;
    hold_sender = 0; mismatches = 0; results_seen = 0;
    for (int i = 0; i < NS; i++) begin
      t_mode[i] = MODE_STOPPED; t_tag[i] = 0; t_per[i] = 0; t_cnt[i] = 0;
      t_lvl[i] = LEVEL_NORM; t_one[i] = 0; t_kind[i] = 0; t_id[i] = NO_ID;
    end
    next_id = 1; ticks = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: extremes, every op, single-shot, stale entries, suspend/resume
    pending_cmds.push_back(mk(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_START, 32'hFFFF_FFFF, 0, 0, 1, 3, 1, 1));
    pending_cmds.push_back(mk(OP_START, 32'h0, 0, 0, 2, 0, 0, 0));
    pending_cmds.push_back(mk(OP_START, 32'hA5A5_5A5A, 0, 0, 0, 2, 0, 1));
    pending_cmds.push_back(mk(OP_START, 32'h1234, 0, 0, 32'hFFFF_FFFF, 1, 0, 0));
    pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_START, 32'h5555, 0, 0, 3, 3, 0, 0));
    pending_cmds.push_back(mk(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 0, 16'd2, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 0, 16'd2, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_RESUME, 0, 16'd3, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_RESUME, 0, 16'd2, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 32'h1234, 0, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_RESUME, 32'h1234, 0, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_STOP, 32'hA5A5_5A5A, 0, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_STOP, 0, 16'hFFFF, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 3, 1, 1));
    pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(mk(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending_cmds.push_back(mk(OP_START, 32'(i), 0, 0, 32'(i % 3 + 1), 2'(i), 0, 1));
    wait (pending_cmds.size() == 0);

    // sender holds off until the table has answered everything
    hold_sender = 1;
    for (int i = 0; i < 5; i++) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    wait (expected_results.size() == 0);
    hold_sender = 0;

    for (int i = 0; i < 400; i++) begin
      pending_cmds.push_back(random_cmd());
      wait (pending_cmds.size() < 4);
    end
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);

    $display("Covered %0d results: ticks, starts, stops, suspends, resumes, dispatches,",
             results_seen);
    $display("  full table, single-shot expiry and unused codes; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
